// ----- hw/rtl/csalu_pkg.sv -----
// csalu_pkg: shared types and constants for the checked signed 64-bit ALU.
// No dependencies; imported by every module of the block.
package csalu_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned DIV_LAT = DATA_W;
  localparam int unsigned MUL_LAT = 3;
  localparam int unsigned MUL_DLY = DIV_LAT - MUL_LAT;

  localparam logic [7:0] OP_ADD = 8'd43;
  localparam logic [7:0] OP_SUB = 8'd45;
  localparam logic [7:0] OP_MUL = 8'd42;
  localparam logic [7:0] OP_DIV = 8'd47;

  localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIVZERO  = 2'd1,
    ST_BADOP    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_ARITH = 2'd0,
    K_MUL   = 2'd1,
    K_DIV   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              neg;
    status_t           st;
    logic [DATA_W-1:0] early;
  } side_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] prod;
  } mul_res_t;

endpackage

// ----- hw/rtl/csalu_mul.sv -----
// csalu_mul: three-stage unsigned 64x64 multiplier built from 32x32 partial
// products, with a flag for products of 2^63 and above. Uses csalu_pkg.
module csalu_mul (
  input  logic                            clk,
  input  logic [csalu_pkg::DATA_W-1:0]    a,
  input  logic [csalu_pkg::DATA_W-1:0]    b,
  output csalu_pkg::mul_res_t             res
);
  import csalu_pkg::*;

  localparam int unsigned HW = DATA_W / 2;

  logic [DATA_W-1:0]   pp_hh, pp_hl, pp_lh, pp_ll;
  logic [DATA_W-1:0]   s2_hh, s2_ll;
  logic [DATA_W:0]     s2_mid;
  logic [2*DATA_W-1:0] full;

  always_ff @(posedge clk) begin
    pp_hh <= a[DATA_W-1:HW] * b[DATA_W-1:HW];
    pp_hl <= a[DATA_W-1:HW] * b[HW-1:0];
    pp_lh <= a[HW-1:0] * b[DATA_W-1:HW];
    pp_ll <= a[HW-1:0] * b[HW-1:0];
  end

  always_ff @(posedge clk) begin
    s2_hh  <= pp_hh;
    s2_ll  <= pp_ll;
    s2_mid <= {1'b0, pp_hl} + {1'b0, pp_lh};
  end

  assign full = {s2_hh, s2_ll} + {{(DATA_W-HW-1){1'b0}}, s2_mid, {HW{1'b0}}};

  always_ff @(posedge clk) begin
    res.ovf  <= |full[2*DATA_W-1:DATA_W-1];
    res.prod <= full[DATA_W-1:0];
  end

endmodule

// ----- hw/rtl/csalu_div.sv -----
// csalu_div: fully pipelined restoring divider for unsigned 64-bit values,
// one quotient bit per register stage. Uses csalu_pkg.
module csalu_div (
  input  logic                            clk,
  input  logic [csalu_pkg::DATA_W-1:0]    dvd,
  input  logic [csalu_pkg::DATA_W-1:0]    dsr,
  output logic [csalu_pkg::DATA_W-1:0]    quo
);
  import csalu_pkg::*;

  logic [DATA_W-1:0] rem_s [DIV_LAT+1];
  logic [DATA_W-1:0] quo_s [DIV_LAT+1];
  logic [DATA_W-1:0] dsr_s [DIV_LAT+1];

  assign rem_s[0] = '0;
  assign quo_s[0] = dvd;
  assign dsr_s[0] = dsr;

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [DATA_W:0] sh;
    logic [DATA_W:0] diff;
    logic            take;

    assign sh   = {rem_s[k], quo_s[k][DATA_W-1]};
    assign diff = sh - {1'b0, dsr_s[k]};
    assign take = !diff[DATA_W];

    always_ff @(posedge clk) begin
      rem_s[k+1] <= take ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
      quo_s[k+1] <= {quo_s[k][DATA_W-2:0], take};
      dsr_s[k+1] <= dsr_s[k];
    end
  end

  assign quo = quo_s[DIV_LAT];

endmodule

// ----- hw/rtl/checked_signed_alu_64.sv -----
// checked_signed_alu_64: top level of the checked signed 64-bit ALU.
// Depends on csalu_pkg, csalu_mul and csalu_div.
//
// Usage:
//   Drive op, lhs and rhs and raise start; the transfer happens at the
//   rising edge where start is high and busy is low. busy is always low,
//   so a new operation may be started in every cycle.
//   Each operation yields one result: done is high for one cycle with value
//   and status, and the result transfers at the edge ending that cycle.
//   Order: done follows the start transfer through the same stages for
//   every operator, so results leave in start order.
//   Throughput: one operation per cycle. The pipeline depth is set by the
//   divider, one register stage per quotient bit (64), plus an input
//   decode stage and an output stage; the three-stage multiplier result
//   waits in a delay line to line up with it.
//   Status: 0 ok, 1 divide by zero, 2 invalid operator, 3 overflow; value
//   is zero whenever status is not ok.
//   Reset (synchronous, active high) drops every operation in flight; no
//   done follows for them. The receiver cannot stall the block.
module checked_signed_alu_64 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [7:0]                          op,
  input  logic signed [csalu_pkg::DATA_W-1:0] lhs,
  input  logic signed [csalu_pkg::DATA_W-1:0] rhs,
  output logic                                done,
  output logic signed [csalu_pkg::DATA_W-1:0] value,
  output csalu_pkg::status_t                  status
);
  import csalu_pkg::*;

  logic              accept;
  logic [DATA_W-1:0] a, b, ma, mb, sum, dif;
  logic              na, nb;
  side_t             side_next;

  logic              s1_vld;
  side_t             s1_side;
  logic [DATA_W-1:0] ma_q, mb_q;

  mul_res_t          mul_res;
  logic [DATA_W-1:0] div_quo;

  logic [DIV_LAT-1:0] vld_pipe;
  side_t              side_pipe [DIV_LAT];
  mul_res_t           mul_pipe  [MUL_DLY];

  side_t             fin_side;
  mul_res_t          fin_mul;
  status_t           fin_st;
  logic [DATA_W-1:0] fin_val;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign a   = lhs;
  assign b   = rhs;
  assign na  = a[DATA_W-1];
  assign nb  = b[DATA_W-1];
  assign ma  = na ? (~a + 1'b1) : a;
  assign mb  = nb ? (~b + 1'b1) : b;
  assign sum = a + b;
  assign dif = a - b;

  always_comb begin
    side_next       = '0;
    side_next.kind  = K_ARITH;
    side_next.neg   = na ^ nb;
    side_next.st    = ST_OK;
    side_next.early = '0;
    case (op)
      OP_ADD: begin
        if ((na == nb) && (sum[DATA_W-1] != na)) side_next.st = ST_OVERFLOW;
        else side_next.early = sum;
      end
      OP_SUB: begin
        if ((na != nb) && (dif[DATA_W-1] != na)) side_next.st = ST_OVERFLOW;
        else side_next.early = dif;
      end
      OP_MUL: begin
        side_next.kind = K_MUL;
      end
      OP_DIV: begin
        side_next.kind = K_DIV;
        if (b == '0) side_next.st = ST_DIVZERO;
        else if (a == MIN_NEG && b == NEG_ONE) side_next.st = ST_OVERFLOW;
      end
      default: begin
        side_next.st = ST_BADOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
    s1_side <= side_next;
    ma_q    <= ma;
    mb_q    <= mb;
  end

  csalu_mul u_mul (
    .clk (clk),
    .a   (ma_q),
    .b   (mb_q),
    .res (mul_res)
  );

  csalu_div u_div (
    .clk (clk),
    .dvd (ma_q),
    .dsr (mb_q),
    .quo (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else begin
      vld_pipe <= {vld_pipe[DIV_LAT-2:0], s1_vld};
    end
    side_pipe[0] <= s1_side;
    for (int i = 1; i < DIV_LAT; i++) side_pipe[i] <= side_pipe[i-1];
    mul_pipe[0] <= mul_res;
    for (int i = 1; i < MUL_DLY; i++) mul_pipe[i] <= mul_pipe[i-1];
  end

  assign fin_side = side_pipe[DIV_LAT-1];
  assign fin_mul  = mul_pipe[MUL_DLY-1];

  always_comb begin
    fin_st  = fin_side.st;
    fin_val = '0;
    if (fin_side.kind == K_MUL && fin_mul.ovf) fin_st = ST_OVERFLOW;
    if (fin_st == ST_OK) begin
      case (fin_side.kind)
        K_ARITH: fin_val = fin_side.early;
        K_MUL:   fin_val = fin_side.neg ? (~fin_mul.prod + 1'b1) : fin_mul.prod;
        K_DIV:   fin_val = fin_side.neg ? (~div_quo + 1'b1) : div_quo;
        default: fin_val = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_pipe[DIV_LAT-1];
    end
    value  <= fin_val;
    status <= fin_st;
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (value == '0))
    else $error("nonzero value on an error result");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(DIV_LAT+2) done)
    else $error("result missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_vld, DIV_LAT + 1))
    else $error("result without a started operation");

  a_divzero_op: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_DIVZERO) |-> ($past(op, DIV_LAT + 2) == OP_DIV))
    else $error("divide-by-zero status on a non-divide");

endmodule
